// ===== hw/rtl/crsa_pkg.sv =====
// Package for the circular record store allocator.
// Holds command and status codes, field widths, defaults and the sequencer state type.
// No dependencies.
`default_nettype none

package crsa_pkg;

    // Default sizing of the record ring and the byte offsets.
    localparam int MAX_RECORDS_DEF = 256;
    localparam int OFFSET_BITS_DEF = 20;

    // Fixed field widths.
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 21;
    localparam int INDEX_W  = 8;
    localparam int SEQ_W    = 32;
    localparam int APB_W    = 32;
    localparam int PADDR_W  = 3;

    // Configuration register reset value.
    localparam logic [SIZE_W-1:0] MEMORY_END_RESET = SIZE_W'(65536);

    // Register select bit of paddr: 0 selects memory_end.
    localparam logic REG_MEMORY_END = 1'b0;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_NEW,
        S_RD_OLD,
        S_FIT,
        S_LOOKUP,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/circular_record_store_allocator_core.sv =====
// Top level of the circular record store allocator: sequencer, record ring memory,
// fit compare unit, configuration register and output register.
// Depends on crsa_pkg.
//
//  Channel   Direction  Handshake                      Word
//  input     in         i_in_valid / o_in_stall        command, record_size, index_from_newest
//  output    out        o_out_valid / i_out_stall      status, address, size, sequence, counts
//  config    in         psel, penable, pwrite, pready  memory_end at byte address 0
//
// Clear, unused commands, allocates into an empty store and lookups past the stored records
// go from idle straight to the finish step; a good lookup passes through the lookup step
// (one registered ring memory read). An allocate into a non-empty store reads the newest,
// then the oldest record, and runs the fit loop: one memory read and one compare per pass.
// Reset is synchronous and active low; the ring memory needs no clearing pass.
// A word waiting in the output register does not block the next input word;
// only the finish step waits while the output is full and stalled.
`default_nettype none

module circular_record_store_allocator_core #(
    parameter int MAX_RECORDS = crsa_pkg::MAX_RECORDS_DEF,
    parameter int OFFSET_BITS = crsa_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [crsa_pkg::CMD_W-1:0]          i_command,
    input  wire logic [crsa_pkg::SIZE_W-1:0]         i_record_size,
    input  wire logic [crsa_pkg::INDEX_W-1:0]        i_index_from_newest,
    // Output channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [crsa_pkg::STATUS_W-1:0]            o_status,
    output logic [OFFSET_BITS-1:0]                   o_record_address,
    output logic [crsa_pkg::SIZE_W-1:0]              o_found_size,
    output logic [crsa_pkg::SEQ_W-1:0]               o_sequence_number,
    output logic [$clog2(MAX_RECORDS+1)-1:0]         o_evicted_count,
    output logic [$clog2(MAX_RECORDS+1)-1:0]         o_records_stored,
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [crsa_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [crsa_pkg::APB_W-1:0]          pwdata,
    output logic [crsa_pkg::APB_W-1:0]               prdata,
    output logic                                     pready
);

    localparam int SIZE_W = crsa_pkg::SIZE_W;
    localparam int SEQ_W  = crsa_pkg::SEQ_W;
    localparam int SW     = $clog2(MAX_RECORDS);
    localparam int CW     = $clog2(MAX_RECORDS+1);
    localparam int LW     = (CW > crsa_pkg::INDEX_W) ? CW : crsa_pkg::INDEX_W;
    localparam int AW     = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 2;
    localparam int EW     = OFFSET_BITS + SIZE_W + SEQ_W;
    localparam logic [AW-1:0] LIMIT = AW'(1) << OFFSET_BITS;

    // Sequencer and bookkeeping registers.
    crsa_pkg::t_state         r_state, n_state;
    logic [SIZE_W-1:0]        r_memory_end;
    logic [SW-1:0]            r_oldest, n_oldest;
    logic [CW-1:0]            r_count, n_count;
    logic [SEQ_W-1:0]         r_next_number, n_next_number;
    logic [SIZE_W-1:0]        r_size, n_size;
    logic [CW-1:0]            r_evicted, n_evicted;
    logic [OFFSET_BITS-1:0]   r_new_start, n_new_start;
    logic [AW-1:0]            r_new_end, n_new_end;
    logic [AW-1:0]            r_new_end_need, n_new_end_need;

    // Result held until the finish step.
    logic [crsa_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [OFFSET_BITS-1:0]        r_res_addr, n_res_addr;
    logic [SIZE_W-1:0]             r_res_size, n_res_size;
    logic [SEQ_W-1:0]              r_res_seq, n_res_seq;

    // Output register.
    logic                          r_o_valid, n_o_valid;
    logic [crsa_pkg::STATUS_W-1:0] r_o_status, n_o_status;
    logic [OFFSET_BITS-1:0]        r_o_addr, n_o_addr;
    logic [SIZE_W-1:0]             r_o_size, n_o_size;
    logic [SEQ_W-1:0]              r_o_seq, n_o_seq;
    logic [CW-1:0]                 r_o_evicted, n_o_evicted;
    logic [CW-1:0]                 r_o_stored, n_o_stored;

    // Record ring memory: start offset, size and sequence number per slot.
    logic [EW-1:0]            r_mem [MAX_RECORDS];
    logic [EW-1:0]            r_rd_data;
    logic                     rd_en;
    logic [SW-1:0]            rd_addr;
    logic                     wr_en;
    logic [SW-1:0]            wr_addr;
    logic [EW-1:0]            wr_data;

    // Fields of the word read from the ring.
    logic [OFFSET_BITS-1:0]   rd_start;
    logic [SIZE_W-1:0]        rd_size;
    logic [SEQ_W-1:0]         rd_seq;

    // Slot pointers and fit compare unit.
    logic [SW-1:0]            slot_free;
    logic [SW-1:0]            slot_newest;
    logic [SW-1:0]            slot_lookup;
    logic [SW-1:0]            oldest_inc;
    logic [LW-1:0]            back_ofs;
    logic                     idx_bad;
    logic [AW-1:0]            need_w;
    logic [AW-1:0]            old_w;
    logic [AW-1:0]            mem_end_w;
    logic [AW-1:0]            region_end;
    logic                     fit_ok;
    logic [OFFSET_BITS-1:0]   fit_addr;
    logic                     out_free;
    logic                     cfg_wr;

    // Wrap a slot sum that is known to stay below twice the ring depth.
    function automatic logic [SW-1:0] slot_wrap(input logic [SW:0] sum);
        if (sum >= (SW+1)'(MAX_RECORDS)) begin
            return SW'(sum - (SW+1)'(MAX_RECORDS));
        end
        return SW'(sum);
    endfunction

    assign rd_start = r_rd_data[EW-1 -: OFFSET_BITS];
    assign rd_size  = r_rd_data[SEQ_W +: SIZE_W];
    assign rd_seq   = r_rd_data[SEQ_W-1:0];

    // Slot pointers derived from the oldest slot and the record count.
    assign slot_free   = slot_wrap((SW+1)'(r_oldest) + (SW+1)'(r_count));
    assign slot_newest = slot_wrap((SW+1)'(r_oldest) + (SW+1)'(r_count) - (SW+1)'(1));
    assign back_ofs    = LW'(r_count) - LW'(1) - LW'(i_index_from_newest);
    assign slot_lookup = slot_wrap((SW+1)'(r_oldest) + (SW+1)'(back_ofs));
    assign oldest_inc  = slot_wrap((SW+1)'(r_oldest) + (SW+1)'(1));
    assign idx_bad     = LW'(i_index_from_newest) >= LW'(r_count);

    // Usable region end, saturated to the offset range.
    assign mem_end_w  = AW'(r_memory_end);
    assign region_end = (mem_end_w > LIMIT) ? LIMIT : mem_end_w;
    assign need_w     = (r_size == '0) ? AW'(1) : AW'(r_size);

    // Fit test against the oldest record that is currently on the read port.
    always_comb begin
        old_w    = AW'(rd_start);
        fit_ok   = 1'b0;
        fit_addr = r_new_end[OFFSET_BITS-1:0];
        if (AW'(r_new_start) >= old_w) begin
            if (old_w == '0) begin
                fit_ok = r_new_end_need <= region_end;
            end else begin
                fit_ok   = need_w <= old_w;
                fit_addr = '0;
            end
        end else begin
            fit_ok = r_new_end_need <= old_w;
        end
    end

    assign out_free   = !r_o_valid || !i_out_stall;
    assign o_in_stall = (r_state != crsa_pkg::S_IDLE);

    // Sequencer: next state, bookkeeping and memory access.
    always_comb begin
        n_state        = r_state;
        n_oldest       = r_oldest;
        n_count        = r_count;
        n_next_number  = r_next_number;
        n_size         = r_size;
        n_evicted      = r_evicted;
        n_new_start    = r_new_start;
        n_new_end      = r_new_end;
        n_new_end_need = r_new_end_need;
        n_res_status   = r_res_status;
        n_res_addr     = r_res_addr;
        n_res_size     = r_res_size;
        n_res_seq      = r_res_seq;
        n_o_valid      = r_o_valid && i_out_stall;
        n_o_status     = r_o_status;
        n_o_addr       = r_o_addr;
        n_o_size       = r_o_size;
        n_o_seq        = r_o_seq;
        n_o_evicted    = r_o_evicted;
        n_o_stored     = r_o_stored;
        rd_en          = 1'b0;
        rd_addr        = r_oldest;
        wr_en          = 1'b0;
        wr_addr        = slot_free;
        wr_data        = {r_res_addr, r_size, r_next_number};

        case (r_state)
            crsa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_size       = i_record_size;
                    n_evicted    = '0;
                    n_res_status = crsa_pkg::ST_OK;
                    n_res_addr   = '0;
                    n_res_size   = '0;
                    n_res_seq    = '0;
                    n_state      = crsa_pkg::S_FINISH;
                    case (i_command)
                        crsa_pkg::CMD_ALLOC: begin
                            if (r_count == '0) begin
                                // Empty store: place at offset 0 whatever the size.
                                wr_en         = 1'b1;
                                wr_data       = {{OFFSET_BITS{1'b0}}, i_record_size,
                                                 r_next_number};
                                n_res_size    = i_record_size;
                                n_res_seq     = r_next_number;
                                n_next_number = r_next_number + SEQ_W'(1);
                                n_count       = r_count + CW'(1);
                            end else begin
                                // Full ring: free one slot before the fit loop.
                                if (r_count == CW'(MAX_RECORDS)) begin
                                    n_oldest  = oldest_inc;
                                    n_count   = r_count - CW'(1);
                                    n_evicted = CW'(1);
                                end
                                n_state = crsa_pkg::S_RD_NEW;
                            end
                        end
                        crsa_pkg::CMD_LOOKUP: begin
                            if (idx_bad) begin
                                n_res_status = crsa_pkg::ST_BAD_INDEX;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = slot_lookup;
                                n_state = crsa_pkg::S_LOOKUP;
                            end
                        end
                        crsa_pkg::CMD_CLEAR: begin
                            n_count  = '0;
                            n_oldest = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            crsa_pkg::S_RD_NEW: begin
                // Fetch the newest record; it stays the same through the fit loop.
                rd_en   = 1'b1;
                rd_addr = slot_newest;
                n_state = crsa_pkg::S_RD_OLD;
            end
            crsa_pkg::S_RD_OLD: begin
                n_new_start    = rd_start;
                n_new_end      = AW'(rd_start) + AW'(rd_size);
                n_new_end_need = AW'(rd_start) + AW'(rd_size) + need_w;
                rd_en          = 1'b1;
                rd_addr        = r_oldest;
                n_state        = crsa_pkg::S_FIT;
            end
            crsa_pkg::S_FIT: begin
                if (fit_ok) begin
                    wr_en         = 1'b1;
                    wr_data       = {fit_addr, r_size, r_next_number};
                    n_res_addr    = fit_addr;
                    n_res_size    = r_size;
                    n_res_seq     = r_next_number;
                    n_next_number = r_next_number + SEQ_W'(1);
                    n_count       = r_count + CW'(1);
                    n_state       = crsa_pkg::S_FINISH;
                end else if (r_count <= CW'(1)) begin
                    // The last record is kept; nothing is placed.
                    n_res_status = crsa_pkg::ST_NO_ROOM;
                    n_state      = crsa_pkg::S_FINISH;
                end else begin
                    // Evict the oldest and read the next oldest for another try.
                    n_oldest  = oldest_inc;
                    n_count   = r_count - CW'(1);
                    n_evicted = r_evicted + CW'(1);
                    rd_en     = 1'b1;
                    rd_addr   = oldest_inc;
                end
            end
            crsa_pkg::S_LOOKUP: begin
                n_res_addr = rd_start;
                n_res_size = rd_size;
                n_res_seq  = rd_seq;
                n_state    = crsa_pkg::S_FINISH;
            end
            crsa_pkg::S_FINISH: begin
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_addr    = r_res_addr;
                    n_o_size    = r_res_size;
                    n_o_seq     = r_res_seq;
                    n_o_evicted = r_evicted;
                    n_o_stored  = r_count;
                    n_state     = crsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = crsa_pkg::S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest      <= '0;
            r_count       <= '0;
            r_next_number <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_oldest      <= n_oldest;
            r_count       <= n_count;
            r_next_number <= n_next_number;
            r_o_valid     <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_size         <= n_size;
        r_evicted      <= n_evicted;
        r_new_start    <= n_new_start;
        r_new_end      <= n_new_end;
        r_new_end_need <= n_new_end_need;
        r_res_status   <= n_res_status;
        r_res_addr     <= n_res_addr;
        r_res_size     <= n_res_size;
        r_res_seq      <= n_res_seq;
        r_o_status     <= n_o_status;
        r_o_addr       <= n_o_addr;
        r_o_size       <= n_o_size;
        r_o_seq        <= n_o_seq;
        r_o_evicted    <= n_o_evicted;
        r_o_stored     <= n_o_stored;
    end

    // Ring memory with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Configuration register.
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[crsa_pkg::PADDR_W-1] == crsa_pkg::REG_MEMORY_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_memory_end <= crsa_pkg::MEMORY_END_RESET;
        end else if (cfg_wr) begin
            r_memory_end <= pwdata[SIZE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[crsa_pkg::PADDR_W-1] == crsa_pkg::REG_MEMORY_END)
                    ? crsa_pkg::APB_W'(r_memory_end) : '0;

    // Output ports.
    assign o_out_valid       = r_o_valid;
    assign o_status          = r_o_status;
    assign o_record_address  = r_o_addr;
    assign o_found_size      = r_o_size;
    assign o_sequence_number = r_o_seq;
    assign o_evicted_count   = r_o_evicted;
    assign o_records_stored  = r_o_stored;

endmodule

`default_nettype wire

// ===== hw/rtl/crsa_checker.sv =====
// Port-level checks for the circular record store allocator, and the bind to its top level.
// Depends on crsa_pkg and circular_record_store_allocator_core.
`default_nettype none

module crsa_checker #(
    parameter int MAX_RECORDS = crsa_pkg::MAX_RECORDS_DEF,
    parameter int OFFSET_BITS = crsa_pkg::OFFSET_BITS_DEF
) (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                o_in_stall,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_stall,
    input wire logic [crsa_pkg::STATUS_W-1:0]       o_status,
    input wire logic [OFFSET_BITS-1:0]              o_record_address,
    input wire logic [crsa_pkg::SIZE_W-1:0]         o_found_size,
    input wire logic [crsa_pkg::SEQ_W-1:0]          o_sequence_number,
    input wire logic [$clog2(MAX_RECORDS+1)-1:0]    o_evicted_count,
    input wire logic [$clog2(MAX_RECORDS+1)-1:0]    o_records_stored
);

    localparam int CW = $clog2(MAX_RECORDS+1);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
        $stable(o_sequence_number) && $stable(o_records_stored))
        else $error("output word changed while stalled");

    // One word at a time: the input side closes right after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted twice in a row");

    // A failed allocate always leaves exactly the last record behind.
    a_no_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == crsa_pkg::ST_NO_ROOM) |->
        (o_records_stored == CW'(1)) && (o_record_address == '0) &&
        (o_found_size == '0) && (o_sequence_number == '0))
        else $error("no_room word inconsistent");

    // A lookup past the stored records reports nothing else.
    a_bad_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == crsa_pkg::ST_BAD_INDEX) |->
        (o_record_address == '0) && (o_found_size == '0) &&
        (o_sequence_number == '0) && (o_evicted_count == '0))
        else $error("bad index word carries data");

    // The record count never passes the ring depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_records_stored <= CW'(MAX_RECORDS)) &&
        (o_evicted_count <= CW'(MAX_RECORDS)))
        else $error("record count out of range");

endmodule

bind circular_record_store_allocator_core crsa_checker #(
    .MAX_RECORDS(MAX_RECORDS),
    .OFFSET_BITS(OFFSET_BITS)
) u_crsa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_status          (o_status),
    .o_record_address  (o_record_address),
    .o_found_size      (o_found_size),
    .o_sequence_number (o_sequence_number),
    .o_evicted_count   (o_evicted_count),
    .o_records_stored  (o_records_stored)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for circular_record_store_allocator_core: directed and random command words,
// checked field by field against a model of the record ring kept inside the bench.
// Depends on crsa_pkg and the core RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = crsa_pkg::MAX_RECORDS_DEF;
    localparam int ADDR_W = crsa_pkg::OFFSET_BITS_DEF;
    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int COUNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [crsa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [crsa_pkg::PADDR_W-1:0] ADDR_MEMORY_END = '0;
    localparam logic [63:0] REGION_CAP = 64'd1 << ADDR_W;
    localparam logic [crsa_pkg::SIZE_W-1:0] SIZE_ALL_ONES = '1;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    // Long enough for the worst allocate, which walks a full ring.
    localparam int TAIL_CYCLES = 300;

    typedef struct packed {
        logic [crsa_pkg::STATUS_W-1:0] status;
        logic [ADDR_W-1:0]             addr;
        logic [crsa_pkg::SIZE_W-1:0]   size;
        logic [crsa_pkg::SEQ_W-1:0]    seq;
        logic [COUNT_W-1:0]            evicted;
        logic [COUNT_W-1:0]            held;
    } t_reply;

    // Clock and reset.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Input channel.
    logic                          i_in_valid = 1'b0;
    wire logic                     o_in_stall;
    logic [crsa_pkg::CMD_W-1:0]    i_command = crsa_pkg::CMD_ALLOC;
    logic [crsa_pkg::SIZE_W-1:0]   i_record_size = '0;
    logic [crsa_pkg::INDEX_W-1:0]  i_index_from_newest = '0;

    // Output channel.
    wire logic                          o_out_valid;
    logic                               i_out_stall = 1'b0;
    wire logic [crsa_pkg::STATUS_W-1:0] o_status;
    wire logic [ADDR_W-1:0]             o_record_address;
    wire logic [crsa_pkg::SIZE_W-1:0]   o_found_size;
    wire logic [crsa_pkg::SEQ_W-1:0]    o_sequence_number;
    wire logic [COUNT_W-1:0]            o_evicted_count;
    wire logic [COUNT_W-1:0]            o_records_stored;

    // Configuration port.
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [crsa_pkg::PADDR_W-1:0] paddr = '0;
    logic [crsa_pkg::APB_W-1:0]   pwdata = '0;
    wire logic [crsa_pkg::APB_W-1:0] prdata;
    wire logic                    pready;

    // Model of the record ring and its registers.
    logic [ADDR_W-1:0]           ring_start [RING_DEPTH];
    logic [crsa_pkg::SIZE_W-1:0] ring_size [RING_DEPTH];
    logic [crsa_pkg::SEQ_W-1:0]  ring_seq [RING_DEPTH];
    logic [SLOT_W-1:0]           ring_head = '0;
    int                          held_count = 0;
    logic [crsa_pkg::SEQ_W-1:0]  next_seq = '0;
    logic [crsa_pkg::SIZE_W-1:0] mem_end_q = crsa_pkg::MEMORY_END_RESET;

    t_reply replies_due[$];
    int     mismatches = 0;
    int     replies_seen = 0;
    int     quiet_cycles = 0;
    int     send_gap_pct = 0;
    int     recv_gap_pct = 0;
    int     holds_asked = 0;
    int     holds_taken = 0;
    int     hold_left = 0;

    circular_record_store_allocator_core u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_command           (i_command),
        .i_record_size       (i_record_size),
        .i_index_from_newest (i_index_from_newest),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_record_address    (o_record_address),
        .o_found_size        (o_found_size),
        .o_sequence_number   (o_sequence_number),
        .o_evicted_count     (o_evicted_count),
        .o_records_stored    (o_records_stored),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Ring slot that lies a given number of records past the oldest one.
    function automatic logic [SLOT_W-1:0] ring_slot(input int offset);
        return SLOT_W'(int'(ring_head) + offset);
    endfunction

    // Looks for a gap of need bytes next to the stored records; the ring must not be empty.
    function automatic bit find_gap(input logic [63:0] need, output logic [63:0] at);
        logic [SLOT_W-1:0] oldest_idx;
        logic [SLOT_W-1:0] newest_idx;
        logic [63:0] old_start;
        logic [63:0] new_start;
        logic [63:0] new_end;
        logic [63:0] limit;
        oldest_idx = ring_slot(0);
        newest_idx = ring_slot(held_count - 1);
        old_start = 64'(ring_start[oldest_idx]);
        new_start = 64'(ring_start[newest_idx]);
        new_end = new_start + 64'(ring_size[newest_idx]);
        limit = (64'(mem_end_q) > REGION_CAP) ? REGION_CAP : 64'(mem_end_q);
        at = '0;
        if (new_start >= old_start) begin
            // Records run forward: space after the newest, or below the oldest.
            if (old_start == 0) begin
                if (new_end + need <= limit) begin
                    at = new_end;
                    return 1'b1;
                end
            end else if (need <= old_start) begin
                return 1'b1;
            end
        end else if (new_end + need <= old_start) begin
            // Records have wrapped: only the hole between newest and oldest is free.
            at = new_end;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one accepted word to the ring model and returns the reply it must produce.
    function automatic t_reply predict_reply(input logic [crsa_pkg::CMD_W-1:0] cmd,
                                             input logic [crsa_pkg::SIZE_W-1:0] size,
                                             input logic [crsa_pkg::INDEX_W-1:0] back);
        t_reply r;
        logic [63:0] need;
        logic [63:0] at;
        bit placed;
        logic [SLOT_W-1:0] slot;
        r = '0;
        case (cmd)
            crsa_pkg::CMD_ALLOC: begin
                // A zero size takes one byte in the fit test but is stored as zero.
                need = (size == 0) ? 64'd1 : 64'(size);
                at = '0;
                placed = (held_count == 0);
                if (!placed) begin
                    // A full ring gives up its oldest slot before any fit test.
                    if (held_count >= RING_DEPTH) begin
                        ring_head = ring_head + 1'b1;
                        held_count--;
                        r.evicted = r.evicted + 1'b1;
                    end
                    placed = find_gap(need, at);
                    while (!placed && held_count > 1) begin
                        ring_head = ring_head + 1'b1;
                        held_count--;
                        r.evicted = r.evicted + 1'b1;
                        placed = find_gap(need, at);
                    end
                end
                if (placed) begin
                    slot = ring_slot(held_count);
                    ring_start[slot] = ADDR_W'(at);
                    ring_size[slot] = size;
                    ring_seq[slot] = next_seq;
                    r.addr = ADDR_W'(at);
                    r.size = size;
                    r.seq = next_seq;
                    next_seq = next_seq + 1'b1;
                    held_count++;
                end else begin
                    r.status = crsa_pkg::ST_NO_ROOM;
                end
            end
            crsa_pkg::CMD_LOOKUP: begin
                if (int'(back) >= held_count) begin
                    r.status = crsa_pkg::ST_BAD_INDEX;
                end else begin
                    slot = ring_slot(held_count - 1 - int'(back));
                    r.addr = ring_start[slot];
                    r.size = ring_size[slot];
                    r.seq = ring_seq[slot];
                end
            end
            crsa_pkg::CMD_CLEAR: begin
                held_count = 0;
                ring_head = '0;
            end
            default: begin
            end
        endcase
        r.held = COUNT_W'(held_count);
        return r;
    endfunction

    // Offers one word after a random gap and records its reply once it is taken.
    task automatic send_word(input logic [crsa_pkg::CMD_W-1:0] cmd,
                             input logic [crsa_pkg::SIZE_W-1:0] size,
                             input logic [crsa_pkg::INDEX_W-1:0] back);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_record_size <= size;
        i_index_from_newest <= back;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        replies_due.push_back(predict_reply(cmd, size, back));
    endtask

    // Random word: mostly allocates, with lookups near the stored depth and some noise.
    task automatic send_random_word(input int size_cap);
        int pick;
        logic [crsa_pkg::CMD_W-1:0] cmd;
        logic [crsa_pkg::SIZE_W-1:0] size;
        logic [crsa_pkg::INDEX_W-1:0] back;
        pick = $urandom_range(99);
        if (pick < 75) cmd = crsa_pkg::CMD_ALLOC;
        else if (pick < 90) cmd = crsa_pkg::CMD_LOOKUP;
        else if (pick < 95) cmd = crsa_pkg::CMD_CLEAR;
        else cmd = CMD_UNUSED;
        pick = $urandom_range(99);
        if (pick < 5) size = '0;
        else if (pick < 12) size = crsa_pkg::SIZE_W'($urandom);
        else if (pick < 25)
            size = crsa_pkg::SIZE_W'($urandom_range(4 * size_cap, size_cap));
        else size = crsa_pkg::SIZE_W'($urandom_range(size_cap, 1));
        if ($urandom_range(99) < 70)
            back = crsa_pkg::INDEX_W'($urandom_range((held_count < 255) ? held_count : 255));
        else
            back = crsa_pkg::INDEX_W'($urandom);
        send_word(cmd, size, back);
    endtask

    // Drops valid and waits until every reply has come back.
    task automatic wait_replies();
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_memory_end(input logic [crsa_pkg::SIZE_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MEMORY_END;
        pwdata <= crsa_pkg::APB_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        mem_end_q = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at reply %0d: %s", replies_seen, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Receiver: random stalls, or a long hold-off when a test asks for one.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (holds_taken != holds_asked) begin
            holds_taken <= holds_taken + 1;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    // Each reply taken is checked against the oldest outstanding prediction.
    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                report_mismatch("reply with no word outstanding");
            end else begin
                want = replies_due.pop_front();
                compare_field("status", 64'(o_status), 64'(want.status));
                compare_field("record_address", 64'(o_record_address), 64'(want.addr));
                compare_field("found_size", 64'(o_found_size), 64'(want.size));
                compare_field("sequence_number", 64'(o_sequence_number), 64'(want.seq));
                compare_field("evicted_count", 64'(o_evicted_count), 64'(want.evicted));
                compare_field("records_stored", 64'(o_records_stored), 64'(want.held));
            end
            replies_seen++;
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Corner cases at the reset region end: empty store, zero size, oversize, wrap-around.
    task automatic test_directed();
        send_word(crsa_pkg::CMD_LOOKUP, '0, '0);
        send_word(CMD_UNUSED, SIZE_ALL_ONES, '1);
        send_word(crsa_pkg::CMD_CLEAR, '0, '0);
        send_word(crsa_pkg::CMD_ALLOC, '0, '0);
        send_word(crsa_pkg::CMD_ALLOC, 21'd100, '0);
        send_word(crsa_pkg::CMD_LOOKUP, '0, 8'd1);
        // Too big to fit beside the last record left.
        send_word(crsa_pkg::CMD_ALLOC, SIZE_ALL_ONES, '0);
        send_word(crsa_pkg::CMD_CLEAR, '0, '0);
        // An empty store takes anything, then has no room for more.
        send_word(crsa_pkg::CMD_ALLOC, SIZE_ALL_ONES, '0);
        send_word(crsa_pkg::CMD_ALLOC, 21'd1, '0);
        send_word(crsa_pkg::CMD_LOOKUP, '0, '0);
        send_word(crsa_pkg::CMD_CLEAR, '0, '0);
        // Fill, evict the oldest, place below it, then wrap and evict again.
        send_word(crsa_pkg::CMD_ALLOC, 21'd30000, '0);
        send_word(crsa_pkg::CMD_ALLOC, 21'd30000, '0);
        send_word(crsa_pkg::CMD_ALLOC, 21'd10000, '0);
        send_word(crsa_pkg::CMD_ALLOC, 21'd20000, '0);
        send_word(crsa_pkg::CMD_ALLOC, 21'd1, '0);
        send_word(crsa_pkg::CMD_LOOKUP, '0, 8'd2);
        send_word(crsa_pkg::CMD_LOOKUP, '0, '0);
        send_word(crsa_pkg::CMD_LOOKUP, '0, 8'd255);
        send_word(crsa_pkg::CMD_LOOKUP, '0, 8'd3);
        send_word(crsa_pkg::CMD_CLEAR, '0, '0);
        wait_replies();
    endtask

    // Small region: frequent eviction and wrap-around.
    task automatic test_tight_region();
        write_memory_end(21'd1000);
        repeat (250) send_random_word(300);
        wait_replies();
    endtask

    // Region end of zero: only the first record into an empty store is placed.
    task automatic test_empty_region();
        write_memory_end('0);
        send_word(crsa_pkg::CMD_CLEAR, '0, '0);
        repeat (20) send_random_word(50);
        wait_replies();
    endtask

    // Tiny records fill every ring slot, so the oldest is dropped to make space.
    task automatic test_full_ring();
        write_memory_end(21'd65536);
        send_word(crsa_pkg::CMD_CLEAR, '0, '0);
        for (int n = 0; n < 280; n++) begin
            send_word(crsa_pkg::CMD_ALLOC, crsa_pkg::SIZE_W'($urandom_range(8, 1)), '0);
            if (n % 10 == 9)
                send_word(crsa_pkg::CMD_LOOKUP, '0, crsa_pkg::INDEX_W'($urandom));
        end
        send_word(crsa_pkg::CMD_LOOKUP, '0, 8'd255);
        send_word(crsa_pkg::CMD_LOOKUP, '0, '0);
        wait_replies();
    endtask

    // Region end above the offset range saturates; then exactly the full range.
    task automatic test_wide_region();
        write_memory_end(SIZE_ALL_ONES);
        send_word(crsa_pkg::CMD_CLEAR, '0, '0);
        repeat (60) send_random_word(200000);
        wait_replies();
        write_memory_end(crsa_pkg::SIZE_W'(REGION_CAP));
        repeat (60) send_random_word(300000);
        wait_replies();
    endtask

    // Region end pulled in below records already stored.
    task automatic test_shrunk_region();
        write_memory_end(21'd65536);
        send_word(crsa_pkg::CMD_CLEAR, '0, '0);
        repeat (10) send_word(crsa_pkg::CMD_ALLOC, 21'd5000, '0);
        wait_replies();
        write_memory_end(21'd20000);
        repeat (30) send_random_word(3000);
        wait_replies();
    endtask

    // Receiver holds off while words keep coming, so the input side must stall.
    task automatic test_backpressure();
        write_memory_end(21'd4000);
        holds_asked++;
        repeat (40) send_random_word(500);
        wait_replies();
    endtask

    // Random region end and random words to close.
    task automatic test_mixed_random();
        write_memory_end(crsa_pkg::SIZE_W'($urandom_range(5000, 200)));
        repeat (60) send_random_word(400);
        wait_replies();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct = 38;
        recv_gap_pct = 67;
        test_directed();
        test_tight_region();
        send_gap_pct = 67;
        recv_gap_pct = 38;
        test_empty_region();
        test_full_ring();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_wide_region();
        test_shrunk_region();
        test_backpressure();
        test_mixed_random();
        wait_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
